>>> rtl/iis_pkg.sv
// ----------------------------------------------------------------------------
// iis_pkg
// Shared types and constants for the streaming integral-image block.
// ----------------------------------------------------------------------------
package iis_pkg;

    // Field widths of the item channels.
    localparam int PIXEL_W   = 8;
    localparam int SUM_W     = 30;
    localparam int ROW_SUM_W = 19;

    // Configuration register layout.
    localparam int CFG_W      = 12;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Default frame limits and register reset values.
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd1920;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd1080;

    // Register indexes on the configuration port.
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } iis_reg_idx_t;

    // Current frame size as written by software.
    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
    } iis_cfg_t;

endpackage

>>> rtl/iis_pix_if.sv
// ----------------------------------------------------------------------------
// iis_pix_if
// Input channel: one pixel item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface iis_pix_if;
    logic                         valid;
    logic                         ready;
    logic [iis_pkg::PIXEL_W-1:0]  pixel;
    logic                         frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

>>> rtl/iis_sum_if.sv
// ----------------------------------------------------------------------------
// iis_sum_if
// Output channel: one integral-sum item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface iis_sum_if;
    logic                        valid;
    logic                        ready;
    logic [iis_pkg::SUM_W-1:0]   integral_sum;
    logic                        frame_end;

    modport source (output valid, output integral_sum, output frame_end, input ready);
    modport sink   (input valid, input integral_sum, input frame_end, output ready);
endinterface

>>> rtl/iis_ram.sv
// ----------------------------------------------------------------------------
// iis_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module iis_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; a read during a write returns the old data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/iis_cfg.sv
// ----------------------------------------------------------------------------
// iis_cfg
// APB register file holding the frame width and height.
// ----------------------------------------------------------------------------
module iis_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [iis_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [iis_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [iis_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output iis_pkg::iis_cfg_t                 cfg
);
    import iis_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] width_next;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] height_next;
    logic             wr_en;
    iis_reg_idx_t     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = iis_reg_idx_t'(paddr[2]);

    // Register write decode.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_FRAME_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default:          width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.frame_width  = width_reg;
    assign cfg.frame_height = height_reg;
endmodule

>>> rtl/integral_image_stream.sv
// ----------------------------------------------------------------------------
// integral_image_stream
// Streaming summed-area table: row running sum plus a line store of the
// previous row's integral values, read-modify-write per pixel.
// ----------------------------------------------------------------------------
// An accepted pixel item passes the second-stage register, then the output
// register, before its result item can be taken.
// Throughput: one item per clock while the output is not stalled; the line
// store does one read at accept and one write as the item leaves the second
// stage, with forwarding when both hit the same column in one cycle.
// Reset clears the counters, the row sum, all valid flags, and sets the size
// registers to defaults; the line store is not cleared: row 0 never uses it.
// ----------------------------------------------------------------------------
module integral_image_stream #(
    parameter int MAX_WIDTH  = iis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iis_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    iis_pix_if.sink                           pix,
    iis_sum_if.source                         sum,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [iis_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [iis_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [iis_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import iis_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int XW = 14;
    localparam logic [XW-1:0] MAX_W_X = XW'(MAX_WIDTH);
    localparam logic [XW-1:0] MAX_H_X = XW'(MAX_HEIGHT);

    iis_cfg_t         cfg;
    logic [CW-1:0]    col_last;
    logic [RW-1:0]    row_last;

    // Position and row-sum state.
    logic [CW-1:0]        col_reg, col_next, col_cur;
    logic [RW-1:0]        row_reg, row_next, row_cur;
    logic [ROW_SUM_W-1:0] row_sum_reg, row_sum_next;
    logic                 last_col, last_row;

    // Second stage: line-store data returns here.
    logic                 s1_valid_reg, s1_valid_next;
    logic [ROW_SUM_W-1:0] s1_row_sum_reg;
    logic                 s1_top_reg;
    logic [CW-1:0]        s1_col_reg;
    logic                 s1_end_reg;
    logic                 s1_fwd_reg;
    logic [SUM_W-1:0]     s1_fwd_data_reg;
    logic                 s1_adv;
    logic [SUM_W-1:0]     above;
    logic [SUM_W-1:0]     total;
    logic [SUM_W-1:0]     ram_rdata;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]     out_sum_reg;
    logic                 out_end_reg;

    logic                 in_acc;

    iis_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Clamp the configured sizes to 1..MAX and take the last index.
    always_comb
    begin
        priority if (cfg.frame_width == '0)
            col_last = '0;
        else if (XW'(cfg.frame_width) > MAX_W_X)
            col_last = CW'(MAX_WIDTH - 1);
        else
            col_last = CW'(XW'(cfg.frame_width) - XW'(1));

        priority if (cfg.frame_height == '0)
            row_last = '0;
        else if (XW'(cfg.frame_height) > MAX_H_X)
            row_last = RW'(MAX_HEIGHT - 1);
        else
            row_last = RW'(XW'(cfg.frame_height) - XW'(1));
    end

    // Handshake: the second stage drains into the output register.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || sum.ready);
    assign pix.ready = !s1_valid_reg || s1_adv;
    assign in_acc    = pix.valid && pix.ready;

    // First stage: counters, row sum, and line-store read address.
    always_comb
    begin
        col_cur  = pix.frame_start ? '0 : col_reg;
        row_cur  = pix.frame_start ? '0 : row_reg;
        last_col = col_cur >= col_last;
        last_row = row_cur >= row_last;
        row_sum_next = ((col_cur == '0) ? '0 : row_sum_reg) + ROW_SUM_W'(pix.pixel);
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_cur + RW'(1);
        end
        else
        begin
            col_next = col_cur + CW'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            row_sum_reg <= '0;
        end
        else if (in_acc)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            row_sum_reg <= row_sum_next;
        end
    end

    // Line store of the previous row's integral values.
    iis_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (total),
        .re    (in_acc),
        .raddr (col_cur),
        .rdata (ram_rdata)
    );

    // Second stage: add the value above; forward when the write is to the
    // column being read in the same cycle (one-pixel-wide frames).
    always_comb
    begin
        if (s1_top_reg)
            above = '0;
        else if (s1_fwd_reg)
            above = s1_fwd_data_reg;
        else
            above = ram_rdata;
        total = SUM_W'(s1_row_sum_reg) + above;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_row_sum_reg  <= row_sum_next;
            s1_top_reg      <= (row_cur == '0);
            s1_col_reg      <= col_cur;
            s1_end_reg      <= last_col && last_row;
            s1_fwd_reg      <= s1_adv && (s1_col_reg == col_cur);
            s1_fwd_data_reg <= total;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (sum.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_sum_reg <= total;
            out_end_reg <= s1_end_reg;
        end
    end

    assign sum.valid        = out_valid_reg;
    assign sum.integral_sum = out_sum_reg;
    assign sum.frame_end    = out_end_reg;

    // Checks on the pipeline and counters.
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && last_col && last_row) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap after the last pixel of a frame");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= CW'(MAX_WIDTH - 1))
        else $error("column counter beyond line store depth");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !sum.ready) |-> !s1_adv)
        else $error("second stage advanced into a stalled output register");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> s1_valid_reg)
        else $error("accepted item lost before the second stage");
endmodule
